// File: rtl/core/tspft_pkg.sv
`default_nettype none
package tspft_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int PID_W         = 13;
    localparam int SLOT_W        = 4;
    localparam int OUTC_W        = 3;
    localparam int DEFAULT_COUNT = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [OUTC_W-1:0] OUT_INSERTED  = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_PRESENT   = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_FULL      = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_REMOVED   = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_NOT_FOUND = 3'd4;
    localparam logic [OUTC_W-1:0] OUT_HIT       = 3'd5;
    localparam logic [OUTC_W-1:0] OUT_MISS      = 3'd6;

    localparam logic [PID_W-1:0] DEFAULT_PIDS [DEFAULT_COUNT] = '{
        13'h0000, 13'h1fff, 13'h0001, 13'h0010,
        13'h0011, 13'h0012, 13'h0013, 13'h1ffb
    };

    typedef struct packed {
        logic [1:0]       op;
        logic [PID_W-1:0] pid;
    } t_in;

    typedef struct packed {
        logic              entry_valid;
        logic [SLOT_W-1:0] filter_slot;
        logic [PID_W-1:0]  slot_pid;
        logic [OUTC_W-1:0] outcome;
        logic              last;
    } t_out;

    typedef struct packed {
        logic             used;
        logic [PID_W-1:0] pid;
    } t_entry;

    function automatic t_entry default_entry(input int idx);
        t_entry e;
        e.used = 1'b0;
        e.pid  = '0;
        if (idx < DEFAULT_COUNT) begin
            e.used = 1'b1;
            e.pid  = DEFAULT_PIDS[idx];
        end
        return e;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/tspft_cell.sv
`default_nettype none
module tspft_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_shift,
    input  tspft_pkg::t_entry    i_rst_val,
    input  tspft_pkg::t_entry    i_d,
    output tspft_pkg::t_entry    o_q
);

    tspft_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= i_rst_val;
        end else if (i_shift) begin
            r_entry <= i_d;
        end
    end

    assign o_q = r_entry;

endmodule
`default_nettype wire

// File: rtl/core/tspft_ctrl.sv
`default_nettype none
module tspft_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  tspft_pkg::t_in       i_data,
    output logic                 o_valid,
    input  wire                  i_stall,
    output tspft_pkg::t_out      o_data,
    input  tspft_pkg::t_entry    i_head,
    output tspft_pkg::t_entry    o_tail,
    output logic                 o_shift
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;
    localparam logic [1:0] S_STATUS = 2'd3;

    localparam logic [tspft_pkg::IDX_W-1:0] STEP_LAST =
        tspft_pkg::IDX_W'(tspft_pkg::TABLE_ENTRIES - 1);

    logic [1:0]                          r_state, n_state;
    logic [1:0]                          r_op, n_op;
    logic [tspft_pkg::PID_W-1:0]         r_pid, n_pid;
    logic [tspft_pkg::IDX_W-1:0]         r_step, n_step;
    logic                                r_hit, n_hit;
    logic                                r_free, n_free;
    logic                                r_done, n_done;
    logic [tspft_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [tspft_pkg::CNT_W-1:0]         r_total, n_total;
    logic [tspft_pkg::CNT_W-1:0]         r_num, n_num;
    logic [tspft_pkg::OUTC_W-1:0]        r_outc, n_outc;
    logic                                r_out_valid, n_out_valid;
    tspft_pkg::t_out                     r_out, n_out;

    logic              adv;
    logic              head_match;
    tspft_pkg::t_entry mod;

    assign adv        = !r_out_valid || !i_stall;
    assign head_match = i_head.used && (i_head.pid == r_pid);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pid       = r_pid;
        n_step      = r_step;
        n_hit       = r_hit;
        n_free      = r_free;
        n_done      = r_done;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_num       = r_num;
        n_outc      = r_outc;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mod         = i_head;
        o_shift     = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid && i_data.op != tspft_pkg::OP_UNUSED) begin
                    n_op    = i_data.op;
                    n_pid   = i_data.pid;
                    n_step  = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_shift = 1'b1;
                n_hit   = r_hit | head_match;
                n_free  = r_free | !i_head.used;
                n_cnt   = r_cnt + tspft_pkg::CNT_W'(i_head.used);
                n_step  = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_step = '0;
                    n_done = 1'b0;
                    n_num  = '0;
                    n_state = S_STATUS;
                    case (r_op)
                        tspft_pkg::OP_ADD: begin
                            if (n_hit) begin
                                n_outc = tspft_pkg::OUT_PRESENT;
                            end else begin
                                n_outc  = n_free ? tspft_pkg::OUT_INSERTED
                                                 : tspft_pkg::OUT_FULL;
                                n_total = n_cnt + tspft_pkg::CNT_W'(n_free);
                                n_state = (n_total == '0) ? S_STATUS : S_EMIT;
                            end
                        end
                        tspft_pkg::OP_REMOVE: begin
                            n_outc  = n_hit ? tspft_pkg::OUT_REMOVED
                                            : tspft_pkg::OUT_NOT_FOUND;
                            n_total = n_cnt - tspft_pkg::CNT_W'(n_hit);
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_outc = n_hit ? tspft_pkg::OUT_HIT : tspft_pkg::OUT_MISS;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (!r_done && r_outc == tspft_pkg::OUT_INSERTED && !i_head.used) begin
                    mod.used = 1'b1;
                    mod.pid  = r_pid;
                end
                if (!r_done && r_outc == tspft_pkg::OUT_REMOVED && head_match) begin
                    mod.used = 1'b0;
                    mod.pid  = '0;
                end
                if (adv) begin
                    o_shift = 1'b1;
                    n_step  = r_step + 1'b1;
                    if (mod != i_head) begin
                        n_done = 1'b1;
                    end
                    if (mod.used) begin
                        n_out_valid       = 1'b1;
                        n_out.entry_valid = 1'b1;
                        n_out.filter_slot = tspft_pkg::SLOT_W'(r_num);
                        n_out.slot_pid    = mod.pid;
                        n_out.outcome     = r_outc;
                        n_out.last        = (r_num == r_total - 1'b1);
                        n_num             = r_num + 1'b1;
                    end
                    if (r_step == STEP_LAST) begin
                        n_step  = '0;
                        n_state = (r_total == '0) ? S_STATUS : S_IDLE;
                    end
                end
            end
            S_STATUS: begin
                if (adv) begin
                    n_out_valid       = 1'b1;
                    n_out.entry_valid = 1'b0;
                    n_out.filter_slot = '0;
                    n_out.slot_pid    = '0;
                    n_out.outcome     = r_outc;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_pid   <= n_pid;
        r_hit   <= n_hit;
        r_free  <= n_free;
        r_cnt   <= n_cnt;
        r_total <= n_total;
        r_num   <= n_num;
        r_outc  <= n_outc;
        r_out   <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_tail  = mod;

endmodule
`default_nettype wire

// File: rtl/core/ts_pid_filter_table_top.sv
// Table entries sit in a ring of cells that rotates one slot per cycle during the search,
// and during the emit pass whenever the output is not stalled. Add/remove: one full rotation
// of search, then a second rotation emitting one list beat per used slot, plus a status beat
// when a remove leaves the table empty.
// Query or duplicate add: a status beat follows the search rotation.
// Reset (sync, active low) loads defaults.
`default_nettype none
module ts_pid_filter_table_top (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  tspft_pkg::t_in     i_data,
    output logic               o_valid,
    input  wire                i_stall,
    output tspft_pkg::t_out    o_data
);

    tspft_pkg::t_entry q [tspft_pkg::TABLE_ENTRIES];
    tspft_pkg::t_entry tail;
    logic              shift;

    genvar g;
    generate
        for (g = 0; g < tspft_pkg::TABLE_ENTRIES; g++) begin : g_cell
            tspft_pkg::t_entry d;
            if (g == tspft_pkg::TABLE_ENTRIES - 1) begin : g_tail
                assign d = tail;
            end else begin : g_mid
                assign d = q[g+1];
            end
            tspft_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_shift   (shift),
                .i_rst_val (tspft_pkg::default_entry(g)),
                .i_d       (d),
                .o_q       (q[g])
            );
        end
    endgenerate

    tspft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .i_head  (q[0]),
        .o_tail  (tail),
        .o_shift (shift)
    );

endmodule
`default_nettype wire
